[sv/u2a_pkg.sv]
// Shared types, codes and folding functions for the UTF-8 to ASCII folder.
`timescale 1ns / 1ps

package u2a_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEAD  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
  localparam logic [1:0] STATUS_UTF16_BOM = 2'd3;

  // Byte constants
  localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
  localparam logic [7:0] BYTE_LEAD2_LO = 8'hc2;
  localparam logic [7:0] BYTE_LEAD_C3  = 8'hc3;
  localparam logic [7:0] BYTE_LEAD3_LO = 8'he0;
  localparam logic [7:0] BYTE_LEAD4_LO = 8'hf0;
  localparam logic [7:0] BYTE_FE       = 8'hfe;
  localparam logic [7:0] BYTE_FF       = 8'hff;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_NEWLINE  = 8'h0a;
  localparam logic [7:0] BYTE_DEL      = 8'h7f;

  // Queue between decoder and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int TOTAL_BITS = 32;

  // How the emitter turns an op byte into a character
  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_C3    = 2'd1,
    KIND_REPL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic                  has_char;
    logic [7:0]            char_out;
    logic [1:0]            status;
    logic                  is_end;
    logic [TOTAL_BITS-1:0] kept_total;
  } result_t;

  // One classified op from decoder to emitter
  typedef struct packed {
    logic       has;
    kind_t      kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       is_end;
  } op_t;

  // Fold a 7-bit byte: lower A-Z; controls other than newline, and DEL, become space
  function automatic logic [7:0] fold_ascii(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b < BYTE_NEWLINE) r = BYTE_SPACE;
    else if (b > BYTE_NEWLINE && b < BYTE_SPACE) r = BYTE_SPACE;
    else if (b >= 8'h41 && b <= 8'h5a) r = b + 8'h20;
    else if (b == BYTE_DEL) r = BYTE_SPACE;
    return r;
  endfunction

  // Transliterate the second byte of a C3 sequence
  function automatic logic [7:0] fold_c3(input logic [7:0] s, input logic [7:0] repl);
    logic [7:0] r;
    r = repl;
    if (s >= 8'h80 && s <= 8'h85) r = 8'h61;
    else if (s >= 8'h88 && s <= 8'h8b) r = 8'h65;
    else if (s >= 8'h8c && s <= 8'h8f) r = 8'h69;
    else if (s >= 8'h92 && s <= 8'h96) r = 8'h6f;
    else if (s >= 8'h99 && s <= 8'h9d) r = 8'h75;
    else if (s >= 8'ha0 && s <= 8'ha5) r = 8'h61;
    else if (s >= 8'ha8 && s <= 8'hab) r = 8'h65;
    else if (s >= 8'hac && s <= 8'haf) r = 8'h69;
    else if (s == 8'hb1) r = 8'h6e;
    else if (s >= 8'hb2 && s <= 8'hb6) r = 8'h6f;
    else if (s >= 8'hb9 && s <= 8'hbc) r = 8'h75;
    return r;
  endfunction

endpackage

[sv/u2a_front.sv]
// Sequence decoder: tracks UTF-8 framing and turns bytes into emitter ops.
`timescale 1ns / 1ps

module u2a_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  u2a_pkg::item_t  item,
  output logic            op_push,
  output u2a_pkg::op_t    op
);

  logic [1:0] skip, skip_next;
  logic       await2, await2_next;
  logic       lead_c3, lead_c3_next;
  logic [1:0] pos, pos_next;
  logic [7:0] first_seen, first_seen_next;
  logic       discard, discard_next;

  // Classify the accepted byte and step the framing state
  always_comb begin
    logic [7:0] b;
    logic       bom;
    logic [1:0] st;
    logic       has;
    logic       fin;
    b = item.in_byte;
    bom = 1'b0;
    st = u2a_pkg::STATUS_OK;
    has = 1'b0;
    fin = 1'b0;
    skip_next = skip;
    await2_next = await2;
    lead_c3_next = lead_c3;
    pos_next = pos;
    first_seen_next = first_seen;
    discard_next = discard;
    op = '0;
    op.kind = u2a_pkg::KIND_ASCII;
    op_push = 1'b0;
    if (accept) begin
      if (discard) begin
        // Drop bytes until the end of the stream
        if (item.in_last) begin
          discard_next = 1'b0;
          skip_next = '0;
          await2_next = 1'b0;
          lead_c3_next = 1'b0;
          pos_next = '0;
          first_seen_next = '0;
        end
      end else begin
        if (pos != 2'd2) pos_next = pos + 2'd1;
        if (pos == 2'd0) first_seen_next = b;
        bom = (pos == 2'd1) &&
              ((first_seen == u2a_pkg::BYTE_FE && b == u2a_pkg::BYTE_FF) ||
               (first_seen == u2a_pkg::BYTE_FF && b == u2a_pkg::BYTE_FE));
        if (bom) begin
          st = u2a_pkg::STATUS_UTF16_BOM;
        end else if (skip != 2'd0) begin
          skip_next = skip - 2'd1;
        end else if (await2) begin
          has = 1'b1;
          op.kind = lead_c3 ? u2a_pkg::KIND_C3 : u2a_pkg::KIND_REPL;
          await2_next = 1'b0;
          lead_c3_next = 1'b0;
        end else if (b < u2a_pkg::BYTE_CONT_LO) begin
          has = 1'b1;
        end else if (b < u2a_pkg::BYTE_LEAD2_LO) begin
          st = u2a_pkg::STATUS_BAD_LEAD;
        end else if (b < u2a_pkg::BYTE_LEAD3_LO) begin
          await2_next = 1'b1;
          lead_c3_next = (b == u2a_pkg::BYTE_LEAD_C3);
        end else if (b < u2a_pkg::BYTE_LEAD4_LO) begin
          skip_next = 2'd2;
        end else begin
          skip_next = 2'd3;
        end
        if (st == u2a_pkg::STATUS_OK && item.in_last &&
            (skip_next != 2'd0 || await2_next)) begin
          st = u2a_pkg::STATUS_TRUNCATED;
        end
        fin = (st != u2a_pkg::STATUS_OK) || item.in_last;
        if (st != u2a_pkg::STATUS_OK) discard_next = 1'b1;
        // End of stream: start the next one clean
        if (item.in_last) begin
          discard_next = 1'b0;
          skip_next = '0;
          await2_next = 1'b0;
          lead_c3_next = 1'b0;
          pos_next = '0;
          first_seen_next = '0;
        end
        op.has = has;
        op.data = b;
        op.status = st;
        op.is_end = fin;
        op_push = has || fin;
      end
    end
  end

  // Hold framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= '0;
      await2 <= 1'b0;
      lead_c3 <= 1'b0;
      pos <= '0;
      first_seen <= '0;
      discard <= 1'b0;
    end else begin
      skip <= skip_next;
      await2 <= await2_next;
      lead_c3 <= lead_c3_next;
      pos <= pos_next;
      first_seen <= first_seen_next;
      discard <= discard_next;
    end
  end

  // A lead of a two-byte sequence and a skip run never coexist
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(await2 && skip != 2'd0))
    else $error("two-byte wait and skip run both active");

  // C3 flag only ever set alongside a pending second byte
  a_c3_with_wait: assert property (@(posedge clk) disable iff (rst)
    lead_c3 |-> await2)
    else $error("C3 flag without pending second byte");

  // Errors always close the stream on the op that reports them
  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    op_push && op.status != u2a_pkg::STATUS_OK |-> op.is_end)
    else $error("error op not marked as end");

endmodule

[sv/u2a_fifo.sv]
// Short op queue between the decoder and the emitter.
`timescale 1ns / 1ps

module u2a_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  u2a_pkg::op_t  wr_data,
  output logic          full,
  input  logic          rd_en,
  output u2a_pkg::op_t  rd_data,
  output logic          empty
);

  localparam int PTR_BITS = $clog2(u2a_pkg::QUEUE_DEPTH);

  u2a_pkg::op_t mem [u2a_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign full    = (count == (PTR_BITS + 1)'(u2a_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + PTR_BITS'(1);
      if (rd_en) rd_ptr <= rd_ptr + PTR_BITS'(1);
      case ({wr_en, rd_en})
        2'b10:   count <= count + (PTR_BITS + 1)'(1);
        2'b01:   count <= count - (PTR_BITS + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("queue read while empty");

endmodule

[sv/u2a_back.sv]
// Emitter: folds queued ops into characters, keeps the count, holds the result.
`timescale 1ns / 1ps

module u2a_back #(
  parameter int COUNT_BITS = u2a_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  u2a_pkg::op_t      op,
  input  logic              op_empty,
  output logic              op_pop,
  output u2a_pkg::result_t  result,
  output logic              empty,
  input  logic              pop
);

  logic [7:0]            repl;
  logic [COUNT_BITS-1:0] kept;
  logic [COUNT_BITS-1:0] kept_next;
  logic                  valid;
  u2a_pkg::result_t      res_next;

  assign op_pop = !op_empty && (!valid || pop);
  assign empty  = !valid;

  // Build the result for the head op
  always_comb begin
    logic [7:0] ch;
    case (op.kind)
      u2a_pkg::KIND_ASCII: ch = u2a_pkg::fold_ascii(op.data);
      u2a_pkg::KIND_C3:    ch = u2a_pkg::fold_c3(op.data, repl);
      u2a_pkg::KIND_REPL:  ch = repl;
      default:             ch = repl;
    endcase
    kept_next = kept;
    if (op.has && kept != '1) kept_next = kept + COUNT_BITS'(1);
    res_next.has_char = op.has;
    res_next.char_out = op.has ? ch : 8'h00;
    res_next.status   = op.status;
    res_next.is_end   = op.is_end;
    res_next.kept_total = '0;
    if (op.is_end) begin
      if (kept_next > COUNT_BITS'({u2a_pkg::TOTAL_BITS{1'b1}})) begin
        res_next.kept_total = '1;
      end else begin
        res_next.kept_total = u2a_pkg::TOTAL_BITS'(kept_next);
      end
    end
  end

  // Hold the replacement register
  always_ff @(posedge clk) begin
    if (rst) repl <= 8'h00;
    else if (cfg_we) repl <= cfg_data;
  end

  // Advance count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= '0;
      valid <= 1'b0;
    end else begin
      if (op_pop) begin
        kept <= op.is_end ? '0 : kept_next;
        valid <= 1'b1;
      end else if (pop) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) result <= res_next;
  end

  a_mid_stream_clean: assert property (@(posedge clk) disable iff (rst)
    valid && !result.is_end |->
      result.status == u2a_pkg::STATUS_OK && result.kept_total == '0)
    else $error("mid-stream result carries status or total");

  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    valid && !result.has_char |-> result.is_end)
    else $error("result with neither character nor end");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    valid && !pop |=> valid && $stable(result))
    else $error("stalled result changed");

endmodule

[sv/utf8_to_ascii_folder.sv]
// Top level of the UTF-8 to ASCII folder: decoder, op queue and emitter.
`timescale 1ns / 1ps

// Usage:
//   Input side is a queue write port: drive item (byte and last flag) and push;
//   a beat is taken on an edge with push high and full low. One byte per clock
//   is accepted while the internal op queue has room.
//   Result side is a queue read port: while empty is low the oldest result is
//   on result; raise pop to take it. Bytes that keep no character and do not
//   close the stream produce no result.
//   Configuration: one write channel (cfg_valid/cfg_ready/cfg_data) sets the
//   replacement byte; cfg_ready is always high. Write it only while idle.
//   Results pass through the 4-beat op queue into the output register.
//   Throughput: one byte per clock while the queue has room, set by the
//   combinational decoder step and the one-result-per-clock emitter.
//   If the receiver stalls, the output register holds and the queue fills;
//   full rises once four ops are waiting, and input stalls until pop.
//   Reset (rst, synchronous) clears the stream state, the queue, the count
//   and sets the replacement byte to zero.
module utf8_to_ascii_folder #(
  parameter int COUNT_BITS = u2a_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  u2a_pkg::item_t    item,
  input  logic              push,
  output logic              full,
  output u2a_pkg::result_t  result,
  output logic              empty,
  input  logic              pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  logic         accept;
  logic         op_push;
  u2a_pkg::op_t op_in;
  u2a_pkg::op_t op_out;
  logic         op_empty;
  logic         op_pop;

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  u2a_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .op_push (op_push),
    .op      (op_in)
  );

  u2a_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (op_push),
    .wr_data (op_in),
    .full    (full),
    .rd_en   (op_pop),
    .rd_data (op_out),
    .empty   (op_empty)
  );

  u2a_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .op       (op_out),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
